// ===== design/sftg_pkg.sv =====
package sftg_pkg;

  // Default upper bound on rows per hemisphere
  localparam int MAX_ROWS_DEF = 64;

  // Field and datapath widths
  localparam int ROW_W    = 7;   // row count, band row, band column
  localparam int CNT_W    = 15;  // facets emitted before the current one
  localparam int FACET_W  = 16;  // facet number, counting from one
  localparam int VTX_W    = 15;  // vertex number
  localparam int COL_W    = 9;   // ring column and ring size (up to 4*65)
  localparam int TRI_W    = 14;  // 2*k*(k-1) row base offset

  localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 7'd8;

  // Walk position through the facet sequence
  typedef struct packed {
    logic [ROW_W-1:0] band_row;
    logic [1:0]       quadrant;
    logic [ROW_W-1:0] band_column;
    logic             pair_half;
    logic [CNT_W-1:0] facet_counter;
    logic             sequence_done;
  } seq_state_t;

  // One result item
  typedef struct packed {
    logic [FACET_W-1:0] facet_number;
    logic [VTX_W-1:0]   vertex_first;
    logic [VTX_W-1:0]   vertex_second;
    logic [VTX_W-1:0]   vertex_third;
    logic               final_facet;
  } facet_t;

  // Position of the first facet
  localparam seq_state_t SEQ_START = '{
    band_row:      ROW_W'(1),
    quadrant:      2'd0,
    band_column:   '0,
    pair_half:     1'b0,
    facet_counter: '0,
    sequence_done: 1'b0
  };

endpackage

// ===== design/sphere_facet_triplet_generator.sv =====
// Channel   Direction  Transaction contents
// s_*       in         s_tdata[0] restart (1: begin again at facet one)
// m_*       out        m_tdata facet number and three vertex numbers,
//                      m_tlast set on the final facet
// apb       in/out     register 0 (byte address 0): row_count, 7 bits
//
// One facet per clock cycle sustained while m_tready is high; a request is
// held in the request register and its result in the result register, which
// drives m_tvalid. The rate is set by the single combinational facet pass between them.
// Reset (rst, synchronous) sets row_count to 8 and the walk to facet one.
// A stalled m_tready holds the result; one more request is still taken.
module sphere_facet_triplet_generator import sftg_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  // facet stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] facet_number, [30:16] vertex_first,
                                 // [45:31] vertex_second, [60:46] vertex_third,
                                 // [63:61] zero
  output logic        m_tlast,   // final_facet
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam int   RESET_ROWS_I  = (8 > MAX_ROWS) ? MAX_ROWS : 8;
  localparam logic [ROW_W-1:0] RESET_ROWS = ROW_W'(RESET_ROWS_I);
  localparam logic [VTX_W-1:0] RESET_QUAD = VTX_W'(4 * RESET_ROWS_I * RESET_ROWS_I);

  logic [ROW_W-1:0]   row_count;
  logic [ROW_W-1:0]   row_eff;
  logic [VTX_W-1:0]   four_n_sq;
  seq_state_t         seq;
  logic               in_valid;
  logic               in_restart;
  logic               out_valid;
  facet_t             out_facet;

  logic               cfg_write;
  logic [ROW_W-1:0]   wr_rows;
  logic [ROW_W-1:0]   wr_eff;
  logic [2*ROW_W-1:0] wr_sq;
  logic               advance;
  seq_state_t         cur;
  seq_state_t         seq_next;
  facet_t             facet;

  // Register port decode and clamp of the written row count
  always_comb begin
    cfg_write = psel && penable && pwrite && (paddr[2] == REG_ROW_COUNT);
    wr_rows   = pwdata[ROW_W-1:0];
    if (wr_rows == '0) begin
      wr_eff = ROW_W'(1);
    end else if (wr_rows > ROW_W'(MAX_ROWS)) begin
      wr_eff = ROW_W'(MAX_ROWS);
    end else begin
      wr_eff = wr_rows;
    end
    wr_sq = {{ROW_W{1'b0}}, wr_eff} * {{ROW_W{1'b0}}, wr_eff};
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROW_COUNT) ? 32'(row_count) : '0;

  // Handshake: move the request into the result register when it has room
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cur      = in_restart ? SEQ_START : seq;

  sftg_facet_calc #(
    .MAX_ROWS (MAX_ROWS)
  ) u_calc (
    .row_eff   (row_eff),
    .four_n_sq (four_n_sq),
    .cur       (cur),
    .facet     (facet),
    .nxt       (seq_next)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RESET;
      row_eff   <= RESET_ROWS;
      four_n_sq <= RESET_QUAD;
      seq       <= SEQ_START;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        row_count <= wr_rows;
        row_eff   <= wr_eff;
        four_n_sq <= VTX_W'({wr_sq, 2'b00});
        seq       <= SEQ_START;
      end else if (advance) begin
        seq <= seq_next;
      end

      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_restart <= s_tdata[0];
    end
    if (advance) begin
      out_facet <= facet;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_facet.vertex_third, out_facet.vertex_second,
                     out_facet.vertex_first, out_facet.facet_number};
  assign m_tlast  = out_facet.final_facet;

endmodule

// ===== design/sftg_facet_calc.sv =====
module sftg_facet_calc import sftg_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic [ROW_W-1:0] row_eff,
  input  logic [VTX_W-1:0] four_n_sq,
  input  seq_state_t       cur,
  output facet_t           facet,
  output seq_state_t       nxt
);

  // Row base offsets 2*k*(k-1) for k = 0 .. MAX_ROWS+2
  localparam int TAB_DEPTH = MAX_ROWS + 3;
  localparam int TIX_W     = $clog2(TAB_DEPTH);

  typedef logic [TRI_W-1:0] tri_tab_t [TAB_DEPTH];

  function automatic tri_tab_t build_tri();
    tri_tab_t tab;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      tab[k] = TRI_W'(2 * k * (k - 1));
    end
    return tab;
  endfunction

  localparam tri_tab_t ROW_TRI = build_tri();

  typedef struct packed {
    logic             pole;
    logic [VTX_W-1:0] pole_val;
    logic [VTX_W-1:0] base;
    logic [COL_W-1:0] ring;
  } row_info_t;

  // Vertex on a ring: wrap the column once, then add the row base; a pole gives its own vertex
  function automatic logic [VTX_W-1:0] row_vertex(input row_info_t r,
                                                  input logic [COL_W-1:0] col);
    logic [COL_W-1:0] col_w;
    col_w = (col >= r.ring) ? col - r.ring : col;
    return r.pole ? r.pole_val : r.base + VTX_W'(col_w);
  endfunction

  logic [ROW_W-1:0] br;
  logic             lower;
  logic [ROW_W-1:0] m;
  logic [ROW_W-1:0] pairs;
  logic [ROW_W-1:0] bc;
  logic             ph;
  logic [1:0]       s;
  logic [COL_W-1:0] mx;
  logic [COL_W-1:0] sx;
  logic [COL_W-1:0] j0;
  logic [COL_W-1:0] j2;
  logic             pair0;
  logic             last;
  logic [ROW_W:0]   ix_a;
  logic [ROW_W:0]   ix_b;
  logic [TRI_W-1:0] tri_a;
  logic [TRI_W-1:0] tri_b;
  row_info_t        row_a;
  row_info_t        row_b;
  logic             sel_b_a, sel_b_b, sel_b_c;
  logic [COL_W-1:0] col_a, col_b, col_c;

  // Band geometry: ring index m of the current row, pair count
  always_comb begin
    br    = (cur.band_row == '0 || cur.band_row > row_eff) ? ROW_W'(1) : cur.band_row;
    lower = VTX_W'(cur.facet_counter) >= four_n_sq;
    m     = lower ? row_eff - br : br;
    pairs = lower ? m : m - ROW_W'(1);
    if (cur.band_column > pairs) begin
      bc = pairs;
      ph = 1'b1;
    end else begin
      bc = cur.band_column;
      ph = cur.pair_half;
    end
    s     = cur.quadrant;
    mx    = COL_W'(m);
    sx    = COL_W'(s);
    j0    = (s[1] ? (mx << 1) : '0) + (s[0] ? mx : '0);
    j2    = j0 + COL_W'(bc);
    pair0 = (bc != '0) && !ph;
    last  = lower && (br == row_eff) && (s == 2'd3);
  end

  // Ring data for the band's own row (A) and the row toward the north pole (B)
  always_comb begin
    ix_a  = lower ? {1'b0, m} + (ROW_W+1)'(1) : {1'b0, m};
    ix_b  = lower ? {1'b0, m} + (ROW_W+1)'(2) : {1'b0, m} - (ROW_W+1)'(1);
    tri_a = ROW_TRI[ix_a[TIX_W-1:0]];
    tri_b = ROW_TRI[ix_b[TIX_W-1:0]];

    row_a.pole     = lower && (m == '0);
    row_a.pole_val = four_n_sq + VTX_W'(2);
    row_a.base     = lower ? four_n_sq + VTX_W'(2) - VTX_W'(tri_a)
                           : VTX_W'(tri_a) + VTX_W'(2);
    row_a.ring     = mx << 2;

    row_b.pole     = !lower && (m == ROW_W'(1));
    row_b.pole_val = VTX_W'(1);
    row_b.base     = lower ? four_n_sq + VTX_W'(2) - VTX_W'(tri_b)
                           : VTX_W'(tri_b) + VTX_W'(2);
    row_b.ring     = lower ? (mx + COL_W'(1)) << 2 : (mx - COL_W'(1)) << 2;
  end

  // Pick row and column of each corner
  always_comb begin
    if (!lower) begin
      if (pair0) begin
        sel_b_a = 1'b0; col_a = j2;
        sel_b_b = 1'b1; col_b = j2 - sx;
        sel_b_c = 1'b1; col_c = j2 - COL_W'(1) - sx;
      end else begin
        sel_b_a = 1'b1; col_a = j2 - sx;
        sel_b_b = 1'b0; col_b = j2;
        sel_b_c = 1'b0; col_c = j2 + COL_W'(1);
      end
    end else begin
      if (pair0) begin
        sel_b_a = 1'b0; col_a = j2;
        sel_b_b = 1'b1; col_b = j2 + sx;
        sel_b_c = 1'b0; col_c = j2 - COL_W'(1);
      end else begin
        sel_b_a = 1'b0; col_a = j2;
        sel_b_b = 1'b1; col_b = j2 + COL_W'(1) + sx;
        sel_b_c = 1'b1; col_c = j2 + sx;
      end
    end
  end

  // Result item
  always_comb begin
    facet.facet_number  = FACET_W'(cur.facet_counter) + FACET_W'(1);
    facet.vertex_first  = row_vertex(sel_b_a ? row_b : row_a, col_a);
    facet.vertex_second = row_vertex(sel_b_b ? row_b : row_a, col_b);
    facet.vertex_third  = row_vertex(sel_b_c ? row_b : row_a, col_c);
    facet.final_facet   = last;
  end

  // Advance the walk; hold it once the final facet has gone out
  always_comb begin
    nxt             = cur;
    nxt.band_row    = br;
    nxt.band_column = bc;
    nxt.pair_half   = ph;
    if (cur.sequence_done || last) begin
      nxt.sequence_done = 1'b1;
    end else begin
      nxt.facet_counter = cur.facet_counter + CNT_W'(1);
      if (pair0) begin
        nxt.pair_half = 1'b1;
      end else if (bc < pairs) begin
        nxt.band_column = bc + ROW_W'(1);
        nxt.pair_half   = 1'b0;
      end else begin
        nxt.band_column = '0;
        nxt.pair_half   = 1'b0;
        if (s != 2'd3) begin
          nxt.quadrant = s + 2'd1;
        end else begin
          nxt.quadrant = 2'd0;
          nxt.band_row = (br >= row_eff) ? ROW_W'(1) : br + ROW_W'(1);
        end
      end
    end
  end

endmodule

// ===== sim/facet_stream_checker.sv =====
module facet_stream_checker import sftg_pkg::*; #(
  parameter int         MAX_ROWS       = MAX_ROWS_DEF,
  parameter logic [2:0] ROW_COUNT_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // [15:0] facet_number, [30:16] vertex_first,
                                 // [45:31] vertex_second, [60:46] vertex_third
  input  logic        m_tlast,   // final_facet
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          facets_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_QUADRANTS = 4;

  // Shadow copy of the register and the facet walk
  logic [ROW_W-1:0] rows_reg;
  int unsigned      walk_row;
  int unsigned      walk_quadrant;
  int unsigned      walk_column;
  int unsigned      walk_half;
  int unsigned      walk_count;
  bit               walk_done;

  facet_t facet_q[$];
  int     fail_count = 0;

  function automatic void restart_walk();
    walk_row      = 1;
    walk_quadrant = 0;
    walk_column   = 0;
    walk_half     = 0;
    walk_count    = 0;
    walk_done     = 1'b0;
  endfunction

  // Vertex number on absolute ring r (0 = north pole, 2n = south pole), column c
  function automatic int unsigned vertex_at(int unsigned n, int unsigned r, int unsigned c);
    int unsigned k;
    if (r == 0) return 1;
    if (r <= n) return 2 + 2 * r * (r - 1) + c % (RING_QUADRANTS * r);
    k = (r <= 2 * n) ? 2 * n - r : 0;
    if (k == 0) return 4 * n * n + 2;
    return 2 + 4 * n * n - 2 * k * (k + 1) + c % (RING_QUADRANTS * k);
  endfunction

  // Produce the facet for one request and step the walk
  function automatic facet_t predict_facet(bit restart);
    int unsigned n, lower, j1, s, m, pairs, j0, j2, va, vb, vc;
    bit          last;
    facet_t      f;
    n = rows_reg;
    if (n == 0) n = 1;
    if (n > MAX_ROWS) n = MAX_ROWS;
    if (restart) restart_walk();
    if (walk_row < 1 || walk_row > n) walk_row = 1;

    lower = (walk_count >= 4 * n * n) ? 1 : 0;
    j1    = lower ? n + walk_row : walk_row;
    s     = walk_quadrant & 3;
    m     = lower ? 2 * n - j1 : j1;
    pairs = lower ? m : m - 1;
    if (walk_column > pairs) begin
      walk_column = pairs;
      walk_half   = 1;
    end
    j0 = s * m;
    j2 = j0 + walk_column;

    // Head triangle, then the two halves of each pair
    if (lower == 0) begin
      if (walk_column == 0) begin
        va = vertex_at(n, j1 - 1, j0 - s);
        vb = vertex_at(n, j1, j0);
        vc = vertex_at(n, j1, j0 + 1);
      end else if (walk_half == 0) begin
        va = vertex_at(n, j1, j2);
        vb = vertex_at(n, j1 - 1, j2 - s);
        vc = vertex_at(n, j1 - 1, j2 - 1 - s);
      end else begin
        va = vertex_at(n, j1 - 1, j2 - s);
        vb = vertex_at(n, j1, j2);
        vc = vertex_at(n, j1, j2 + 1);
      end
    end else begin
      if (walk_column == 0) begin
        va = vertex_at(n, j1, j0);
        vb = vertex_at(n, j1 - 1, j0 + 1 + s);
        vc = vertex_at(n, j1 - 1, j0 + s);
      end else if (walk_half == 0) begin
        va = vertex_at(n, j1, j2);
        vb = vertex_at(n, j1 - 1, j2 + s);
        vc = vertex_at(n, j1, j2 - 1);
      end else begin
        va = vertex_at(n, j1, j2);
        vb = vertex_at(n, j1 - 1, j2 + 1 + s);
        vc = vertex_at(n, j1 - 1, j2 + s);
      end
    end

    last            = (lower != 0) && (walk_row == n) && (s == 3);
    f.facet_number  = FACET_W'(walk_count + 1);
    f.vertex_first  = VTX_W'(va);
    f.vertex_second = VTX_W'(vb);
    f.vertex_third  = VTX_W'(vc);
    f.final_facet   = last;

    // Hold on the last facet, else advance
    if (walk_done || last) begin
      walk_done = 1'b1;
    end else begin
      walk_count = (walk_count + 1) & 32'h7FFF;
      if (walk_column != 0 && walk_half == 0) begin
        walk_half = 1;
      end else if (walk_column < pairs) begin
        walk_column++;
        walk_half = 0;
      end else begin
        walk_column = 0;
        walk_half   = 0;
        if (s < 3) begin
          walk_quadrant = s + 1;
        end else begin
          walk_quadrant = 0;
          walk_row      = (walk_row >= n) ? 1 : walk_row + 1;
        end
      end
    end
    return f;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
    end
  endtask

  // Compare results first, then queue the prediction for a new request
  always @(posedge clk) begin
    facet_t want;
    if (rst) begin
      rows_reg = ROW_COUNT_RESET;
      restart_walk();
      facet_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (facet_q.size() == 0) begin
          fail_count++;
          $display("%0t: facet transaction, expected none actual facet %0d",
                   $time, m_tdata[15:0]);
        end else begin
          want = facet_q.pop_front();
          check_field("facet_number", 16'(want.facet_number), m_tdata[15:0]);
          check_field("vertex_first", 16'(want.vertex_first), 16'(m_tdata[30:16]));
          check_field("vertex_second", 16'(want.vertex_second), 16'(m_tdata[45:31]));
          check_field("vertex_third", 16'(want.vertex_third), 16'(m_tdata[60:46]));
          check_field("final_facet", 16'(want.final_facet), 16'(m_tlast));
        end
      end
      if (s_tvalid && s_tready)
        facet_q.push_back(predict_facet(s_tdata[0]));
      // A row count write also restarts the walk
      if (psel && penable && pwrite && pready && paddr == ROW_COUNT_ADDR) begin
        rows_reg = pwdata[ROW_W-1:0];
        restart_walk();
      end
    end
    facets_pending <= facet_q.size();
    mismatches     <= fail_count;
  end

endmodule

// ===== sim/sphere_facet_triplet_generator_tb.sv =====
module sphere_facet_triplet_generator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ROW_COUNT_ADDR = 3'd0;
  localparam int         RANDOM_ITEMS   = 1050;
  localparam int         HOLD_OFF_AT    = 300;
  localparam int         HOLD_OFF_LEN   = 80;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = 3'd0;
  logic [31:0] pwdata  = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int facets_pending;
  int requests_sent = 0;

  always #1 clk = ~clk;

  sphere_facet_triplet_generator dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  facet_stream_checker #(
    .ROW_COUNT_ADDR(ROW_COUNT_ADDR)
  ) facet_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .facets_pending(facets_pending)
  );

  // Window in which neither side idles
  function automatic bit quiet_span();
    return requests_sent >= 500 && requests_sent < 700;
  endfunction

  // Offer one request, wait for the transaction, then maybe idle
  task automatic send_request(input bit restart);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (!quiet_span() && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop the request stream and let every facet drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (facets_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write of row_count with junk in the unused upper bits
  task automatic write_rows(input logic [6:0] rows);
    logic [31:0] noise;
    noise = $urandom();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROW_COUNT_ADDR;
    pwdata  <= {noise[31:7], rows};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off while requests keep coming
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && requests_sent >= HOLD_OFF_AT) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet_span() || $urandom_range(0, 99) >= 7;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned rows;
    int unsigned batch;
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset row count: first facets, then a restart
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();

    // One row: run past the end so the last facet repeats, then restart
    write_rows(7'd1);
    repeat (10) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_idle();

    // Row count of zero behaves as one
    write_rows(7'd0);
    repeat (9) send_request(1'b0);
    wait_idle();

    // Random phases: full walks on small spheres, partial walks on large ones
    phase = 0;
    while (requests_sent < RANDOM_ITEMS - 60) begin
      case (phase)
        0: rows = 127;
        1: rows = 5;
        2: rows = 64;
        default: rows = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 127)
                                                    : $urandom_range(1, 4);
      endcase
      write_rows(rows[6:0]);
      batch = (rows >= 1 && rows <= 5) ? 8 * rows * rows + $urandom_range(2, 12)
                                       : $urandom_range(40, 80);
      repeat (batch) send_request($urandom_range(0, 79) == 0);
      wait_idle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && facets_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
